/* hw/rtl/qtbm_pkg.sv */
// Shared codes, field widths and result types for the quota/TTL buffer manager.
// Depends on nothing; qtbm_page and the top level import it.
package qtbm_pkg;

	localparam int TIME_W = 32;
	localparam int LEN_W  = 32;
	localparam int OFF_W  = 32;
	localparam int MAXB_W = 31;
	localparam int TTL_W  = 17;
	localparam int LIM_W  = 7;
	localparam int BUD_W  = 32;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_TTL    = 2'd0;
	localparam logic [CFG_AW-1:0] REG_LIMIT  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_BUDGET = 2'd2;

	localparam logic [TTL_W-1:0] TTL_RESET    = 17'd600;
	localparam logic [LIM_W-1:0] LIMIT_RESET  = 7'd16;
	localparam logic [BUD_W-1:0] BUDGET_RESET = 32'd67108864;

	// actions
	localparam logic [1:0] ACT_STORE   = 2'd0;
	localparam logic [1:0] ACT_PAGE    = 2'd1;
	localparam logic [1:0] ACT_CLR_SES = 2'd2;
	localparam logic [1:0] ACT_CLR_ALL = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_TOO_LARGE = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0]  total_length;
		logic [MAXB_W-1:0] page_length;
		logic              complete;
		logic [OFF_W-1:0]  next_off;
	} page_res_t;

endpackage

/* hw/rtl/qtbm_mem.sv */
// Entry record memory: one write port, one registered read port.
// Depends on nothing; width and depth come from the instantiating level.
module qtbm_mem #(
	parameter int W     = 8,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/qtbm_page.sv */
// Page span unit: clips a page against the entry length in three registered steps.
// Depends on qtbm_pkg for widths and the result struct.
module qtbm_page
	import qtbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LEN_W-1:0]  total,
	input  logic [OFF_W-1:0]  offset,
	input  logic [MAXB_W-1:0] page_limit,
	output logic              done,
	output page_res_t         res
);

	logic               v_s1, v_s2, v_s3;
	logic signed [33:0] off_s1, off_s2;
	logic signed [33:0] tot_s1, tot_s2;
	logic signed [33:0] diff_s1;
	logic               inr_s1;
	logic [MAXB_W-1:0]  max_s1;
	logic [MAXB_W-1:0]  page_s2;
	logic signed [33:0] off_ext, tot_ext, next_sum;

	assign off_ext  = 34'(signed'(offset));
	assign tot_ext  = signed'({2'b00, total});
	assign next_sum = off_s2 + signed'({3'b000, page_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// in range and remaining length
		off_s1  <= off_ext;
		tot_s1  <= tot_ext;
		max_s1  <= page_limit;
		inr_s1  <= (off_ext >= 34'sd0) && (off_ext <= tot_ext);
		diff_s1 <= tot_ext - off_ext;
		// clip to the page limit
		off_s2 <= off_s1;
		tot_s2 <= tot_s1;
		if (!inr_s1) begin
			page_s2 <= '0;
		end else if (diff_s1 > signed'({3'b000, max_s1})) begin
			page_s2 <= max_s1;
		end else begin
			page_s2 <= diff_s1[MAXB_W-1:0];
		end
		// next offset and completion
		res.total_length <= tot_s2[LEN_W-1:0];
		res.page_length  <= page_s2;
		res.complete     <= (next_sum >= tot_s2);
		res.next_off     <= next_sum[OFF_W-1:0];
	end

	assign done = v_s3;

endmodule

/* hw/rtl/quota_ttl_buffer_manager.sv */
// Top level of the quota/TTL buffer manager: sequencer, entry scan unit and ports.
// Depends on qtbm_pkg, qtbm_mem and qtbm_page.
//
// Channel   Dir  Handshake                    Carries
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser action, tdata request fields
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata result fields
// cfg       in   cfg_wen                      cfg_addr register index, cfg_wdata value
//
// One shared scan unit walks the entry memory one slot a cycle, one read port.
// A page takes one pass plus the page unit; a clear session takes one pass; a store takes
// 3 + k passes where k is the number of budget evictions, fewer if refused as too large.
// Clear all takes no pass.
// Reset clears valid bits, generation marks, byte total and config to defaults.
// The request side is ready only when idle; a finished result waits in the output
// register and the next request may be taken while it is still pending.
module quota_ttl_buffer_manager
	import qtbm_pkg::*;
#(
	parameter int ENTRIES  = 64,
	parameter int TAG_BITS = 16,
	parameter int GEN_BITS = 8,
	localparam int IW      = $clog2(ENTRIES),
	localparam int I_SE    = TAG_BITS,
	localparam int I_NOW   = 2 * TAG_BITS,
	localparam int I_LEN   = I_NOW + TIME_W,
	localparam int I_HS    = I_LEN + LEN_W,
	localparam int I_HG    = I_HS + IW,
	localparam int I_OFF   = I_HG + GEN_BITS,
	localparam int I_MAX   = I_OFF + OFF_W,
	localparam int IN_W    = I_MAX + MAXB_W,
	localparam int IN_DW   = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W   = 2 + IW + GEN_BITS + $bits(page_res_t),
	localparam int OUT_DW  = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// low to high: principal, session, now_seconds, length, handle_slot,
	// handle_generation, offset, page limit, zero fill
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// action
	input  logic [1:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// low to high: status, slot, generation, total_length, page_length, complete,
	// next_off, zero fill
	output logic [OUT_DW-1:0] m_axis_tdata,
	input  logic              cfg_wen,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	typedef struct packed {
		logic [TAG_BITS-1:0] principal;
		logic [TAG_BITS-1:0] session;
		logic [TIME_W-1:0]   created;
		logic [TIME_W-1:0]   expires;
		logic [LEN_W-1:0]    length;
		logic [GEN_BITS-1:0] generation;
	} rec_t;

	// sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SCAN    = 4'd1;
	localparam logic [3:0] ST_EVAL    = 4'd2;
	localparam logic [3:0] ST_BUDGET  = 4'd3;
	localparam logic [3:0] ST_GEN_RD  = 4'd4;
	localparam logic [3:0] ST_WRITE   = 4'd5;
	localparam logic [3:0] ST_PG_RD   = 4'd6;
	localparam logic [3:0] ST_PG_CHK  = 4'd7;
	localparam logic [3:0] ST_PG_WAIT = 4'd8;
	localparam logic [3:0] ST_FIN     = 4'd9;

	// scan pass kinds
	localparam logic [2:0] P_SWEEP  = 3'd0;
	localparam logic [2:0] P_OWNER  = 3'd1;
	localparam logic [2:0] P_OLDEST = 3'd2;
	localparam logic [2:0] P_FINAL  = 3'd3;
	localparam logic [2:0] P_CLRSES = 3'd4;

	logic [3:0]          state_q;
	logic [2:0]          pass_q;

	// request fields
	logic [1:0]          act_q;
	logic [TAG_BITS-1:0] p_q, s_q;
	logic [TIME_W-1:0]   now_q;
	logic [LEN_W-1:0]    len_q;
	logic [IW-1:0]       hslot_q;
	logic [GEN_BITS-1:0] hgen_q;
	logic [OFF_W-1:0]    off_q;
	logic [MAXB_W-1:0]   maxb_q;

	// configuration
	logic [TTL_W-1:0]    ttl_q;
	logic [LIM_W-1:0]    lim_q;
	logic [BUD_W-1:0]    budget_q;

	// per-entry flags and byte total
	logic [ENTRIES-1:0]  valid_q;
	logic [ENTRIES-1:0]  genok_q;
	logic [LEN_W:0]      bytes_q;

	// scan unit
	logic [IW:0]         issue_q;
	logic                proc_v_s1;
	logic [IW-1:0]       proc_idx_s1;
	logic                found_q;
	logic [IW-1:0]       best_q;
	logic [TIME_W-1:0]   best_cr_q;
	logic [LEN_W-1:0]    best_len_q;
	logic [IW:0]         cnt_q;
	logic                free_found_q;
	logic [IW-1:0]       free_q;
	logic                empty_q;
	logic [IW-1:0]       slot_q;

	// result
	logic [1:0]          res_status_q;
	logic [IW-1:0]       res_slot_q;
	logic [GEN_BITS-1:0] res_gen_q;
	page_res_t           res_pg_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	// memory and page unit
	logic                mem_we;
	logic [IW-1:0]       mem_raddr;
	rec_t                rd_rec;
	rec_t                wr_rec;
	logic                pg_start;
	logic                pg_done;
	page_res_t           pg_res;

	logic                cur_v;
	logic                older;
	logic                owner_hit;
	logic [TIME_W:0]     exp_sum;
	logic [TIME_W-1:0]   exp_sat;
	logic [LEN_W+1:0]    need;
	logic                over_budget;
	logic [GEN_BITS-1:0] stored_gen;
	logic [GEN_BITS-1:0] new_gen;
	logic [GEN_BITS-1:0] pg_gen;
	logic                pg_bad;

	qtbm_mem #(
		.W     ($bits(rec_t)),
		.DEPTH (ENTRIES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (wr_rec),
		.raddr (mem_raddr),
		.rdata (rd_rec)
	);

	qtbm_page u_page (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (pg_start),
		.total      (rd_rec.length),
		.offset     (off_q),
		.page_limit (maxb_q),
		.done       (pg_done),
		.res        (pg_res)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DW'(out_data_q);

	// scan compare: entry under the read port against the running best
	assign cur_v     = valid_q[proc_idx_s1];
	assign older     = !found_q || (rd_rec.created < best_cr_q);
	assign owner_hit = (rd_rec.principal == p_q) && (rd_rec.session == s_q);

	assign exp_sum     = {1'b0, now_q} + (TIME_W + 1)'(ttl_q);
	assign exp_sat     = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
	assign need        = {1'b0, bytes_q} + {2'b00, len_q};
	assign over_budget = need > {2'b00, budget_q};

	assign stored_gen = genok_q[slot_q] ? rd_rec.generation : '0;
	assign new_gen    = stored_gen + GEN_BITS'(1);
	assign pg_gen     = genok_q[hslot_q] ? rd_rec.generation : '0;
	assign pg_bad     = (32'(hslot_q) >= ENTRIES) || !valid_q[hslot_q] ||
			(pg_gen != hgen_q) || (rd_rec.principal != p_q) ||
			(rd_rec.session != s_q);

	always_comb begin
		wr_rec.principal  = p_q;
		wr_rec.session    = s_q;
		wr_rec.created    = now_q;
		wr_rec.expires    = exp_sat;
		wr_rec.length     = len_q;
		wr_rec.generation = new_gen;
	end

	assign mem_we   = (state_q == ST_WRITE);
	assign pg_start = (state_q == ST_PG_CHK) && !pg_bad;

	always_comb begin
		case (state_q)
			ST_SCAN:  mem_raddr = issue_q[IW-1:0];
			ST_GEN_RD: mem_raddr = slot_q;
			ST_PG_RD: mem_raddr = hslot_q;
			default:  mem_raddr = issue_q[IW-1:0];
		endcase
	end

	// configuration registers, written whenever the port asks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q    <= TTL_RESET;
			lim_q    <= LIMIT_RESET;
			budget_q <= BUDGET_RESET;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_TTL:    ttl_q    <= cfg_wdata[TTL_W-1:0];
				REG_LIMIT:  lim_q    <= cfg_wdata[LIM_W-1:0];
				REG_BUDGET: budget_q <= cfg_wdata[BUD_W-1:0];
				default:    ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q   <= s_axis_tuser;
			p_q     <= s_axis_tdata[TAG_BITS-1:0];
			s_q     <= s_axis_tdata[I_SE +: TAG_BITS];
			now_q   <= s_axis_tdata[I_NOW +: TIME_W];
			len_q   <= s_axis_tdata[I_LEN +: LEN_W];
			hslot_q <= s_axis_tdata[I_HS +: IW];
			hgen_q  <= s_axis_tdata[I_HG +: GEN_BITS];
			off_q   <= s_axis_tdata[I_OFF +: OFF_W];
			maxb_q  <= s_axis_tdata[I_MAX +: MAXB_W];
		end
	end

	// sequencer, scan unit and entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pass_q       <= P_SWEEP;
			valid_q      <= '0;
			genok_q      <= '0;
			bytes_q      <= '0;
			issue_q      <= '0;
			proc_v_s1    <= 1'b0;
			proc_idx_s1  <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_cr_q    <= '0;
			best_len_q   <= '0;
			cnt_q        <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			empty_q      <= 1'b0;
			slot_q       <= '0;
			res_status_q <= STAT_OK;
			res_slot_q   <= '0;
			res_gen_q    <= '0;
			res_pg_q     <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						res_status_q <= STAT_OK;
						res_slot_q   <= '0;
						res_gen_q    <= '0;
						res_pg_q     <= '0;
						empty_q      <= 1'b0;
						issue_q      <= '0;
						found_q      <= 1'b0;
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						case (s_axis_tuser)
							ACT_CLR_ALL: begin
								// drop everything, keep generations
								valid_q <= '0;
								bytes_q <= '0;
								state_q <= ST_FIN;
							end
							ACT_CLR_SES: begin
								pass_q  <= P_CLRSES;
								state_q <= ST_SCAN;
							end
							default: begin
								pass_q  <= P_SWEEP;
								state_q <= ST_SCAN;
							end
						endcase
					end
				end

				ST_SCAN: begin
					// issue one read a cycle, judge it the next
					if (32'(issue_q) < ENTRIES) begin
						issue_q     <= issue_q + (IW + 1)'(1);
						proc_v_s1   <= 1'b1;
						proc_idx_s1 <= issue_q[IW-1:0];
					end else begin
						proc_v_s1 <= 1'b0;
					end
					if (proc_v_s1) begin
						case (pass_q)
							P_SWEEP: begin
								if (cur_v && (now_q >= rd_rec.expires)) begin
									valid_q[proc_idx_s1] <= 1'b0;
									bytes_q <= bytes_q - {1'b0, rd_rec.length};
								end
							end
							P_CLRSES: begin
								if (cur_v && (rd_rec.session == s_q)) begin
									valid_q[proc_idx_s1] <= 1'b0;
									bytes_q <= bytes_q - {1'b0, rd_rec.length};
								end
							end
							P_OWNER: begin
								if (cur_v && owner_hit) begin
									cnt_q <= cnt_q + (IW + 1)'(1);
									if (older) begin
										found_q    <= 1'b1;
										best_q     <= proc_idx_s1;
										best_cr_q  <= rd_rec.created;
										best_len_q <= rd_rec.length;
									end
								end
							end
							default: begin
								// oldest overall; final pass also notes first free slot
								if (cur_v && older) begin
									found_q    <= 1'b1;
									best_q     <= proc_idx_s1;
									best_cr_q  <= rd_rec.created;
									best_len_q <= rd_rec.length;
								end
								if (!cur_v && !free_found_q) begin
									free_found_q <= 1'b1;
									free_q       <= proc_idx_s1;
								end
							end
						endcase
						if (32'(proc_idx_s1) == ENTRIES - 1) begin
							state_q <= ST_EVAL;
						end
					end
				end

				ST_EVAL: begin
					issue_q      <= '0;
					found_q      <= 1'b0;
					cnt_q        <= '0;
					free_found_q <= 1'b0;
					case (pass_q)
						P_SWEEP: begin
							if (act_q == ACT_STORE) begin
								pass_q  <= P_OWNER;
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_PG_RD;
							end
						end
						P_OWNER: begin
							// owner at quota: drop its oldest
							if (found_q && (32'(cnt_q) >= 32'(lim_q))) begin
								valid_q[best_q] <= 1'b0;
								bytes_q <= bytes_q - {1'b0, best_len_q};
							end
							state_q <= ST_BUDGET;
						end
						P_OLDEST: begin
							if (found_q) begin
								valid_q[best_q] <= 1'b0;
								bytes_q <= bytes_q - {1'b0, best_len_q};
							end else begin
								empty_q <= 1'b1;
							end
							state_q <= ST_BUDGET;
						end
						P_FINAL: begin
							// reuse the oldest slot when the table is full
							if (free_found_q) begin
								slot_q <= free_q;
							end else begin
								slot_q          <= best_q;
								valid_q[best_q] <= 1'b0;
								bytes_q <= bytes_q - {1'b0, best_len_q};
							end
							state_q <= ST_GEN_RD;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end

				ST_BUDGET: begin
					if (over_budget && !empty_q) begin
						pass_q  <= P_OLDEST;
						state_q <= ST_SCAN;
					end else if (len_q > budget_q) begin
						res_status_q <= STAT_TOO_LARGE;
						state_q      <= ST_FIN;
					end else begin
						pass_q  <= P_FINAL;
						state_q <= ST_SCAN;
					end
				end

				ST_GEN_RD: begin
					state_q <= ST_WRITE;
				end

				ST_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					genok_q[slot_q] <= 1'b1;
					bytes_q         <= bytes_q + {1'b0, len_q};
					res_slot_q      <= slot_q;
					res_gen_q       <= new_gen;
					state_q         <= ST_FIN;
				end

				ST_PG_RD: begin
					state_q <= ST_PG_CHK;
				end

				ST_PG_CHK: begin
					if (pg_bad) begin
						res_status_q <= STAT_NOT_FOUND;
						state_q      <= ST_FIN;
					end else begin
						state_q <= ST_PG_WAIT;
					end
				end

				ST_PG_WAIT: begin
					if (pg_done) begin
						res_pg_q <= pg_res;
						state_q  <= ST_FIN;
					end
				end

				ST_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {res_pg_q.next_off, res_pg_q.complete,
								res_pg_q.page_length, res_pg_q.total_length,
								res_gen_q, res_slot_q, res_status_q};
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
